[rtl/core/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared widths, constants and types of the rotating scan point converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // binary angle format, one turn is 2^ANGLE_BITS
  localparam int ANGLE_BITS     = 20;
  localparam int BEAMS_PER_LINE = 361;

  localparam int RANGE_W    = 16;
  localparam int BEAM_W     = 10;
  localparam int TIME_W     = 26;
  localparam int STEP_W     = 20;
  localparam int RATE_W     = 32;
  localparam int COORD_W    = 17;
  localparam int TRIG_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // low product bits needed for the rounded sweep angle
  localparam int SWEEP_PW = 16 + ANGLE_BITS;
  // elevation product width
  localparam int ELEV_PW  = BEAM_W + STEP_W;
  // quarter-wave argument, 0 up to one quarter turn inclusive
  localparam int QTR_W    = ANGLE_BITS - 1;
  localparam int TO_Q30   = 32 - ANGLE_BITS;

  localparam logic [QTR_W-1:0]  QUARTER    = QTR_W'(1) << (ANGLE_BITS - 2);
  localparam logic [BEAM_W:0]   BEAM_LIMIT = (BEAM_W + 1)'(BEAMS_PER_LINE);

  // quarter-wave sine polynomial coefficients, Q30
  localparam logic [30:0] K1 = 31'd1686629713;
  localparam logic [29:0] K3 = 30'd693598668;
  localparam logic [26:0] K5 = 27'd85569306;
  localparam logic [22:0] K7 = 23'd5026995;
  localparam logic [17:0] K9 = 18'd172272;

  // pipeline depths
  localparam int ANG_LAT  = 3;
  localparam int SC_LAT   = 8;
  localparam int PRJ_LAT  = 3;
  localparam int PIPE_LAT = ANG_LAT + SC_LAT + PRJ_LAT;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_STEP     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START_AZIMUTH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_RATE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_REVERSE = CFG_IDX_W'(3);

  typedef struct packed {
    logic [STEP_W-1:0] beam_step;
    logic [STEP_W-1:0] start_azimuth;
    logic [RATE_W-1:0] rotation_rate;
    logic              sweep_reverse;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    beam_step:     STEP_W'(1456),
    start_azimuth: '0,
    rotation_rate: '0,
    sweep_reverse: 1'b0
  };

  // per-request control that rides alongside the angle and trig data
  typedef struct packed {
    logic               vld;
    logic               bad;
    logic [RANGE_W-1:0] range_mm;
  } meta_t;

  typedef logic signed [TRIG_W-1:0] trig_t;

endpackage

[rtl/core/rsc_angle.sv]
// ----------------------------------------------------------------------------
// rsc_angle
// Elevation and azimuth binary angles of a request, three register stages.
// ----------------------------------------------------------------------------
module rsc_angle (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_vld,
  input  logic [rsc_pkg::RANGE_W-1:0]     range_mm,
  input  logic [rsc_pkg::BEAM_W-1:0]      beam_index,
  input  logic [rsc_pkg::TIME_W-1:0]      elapsed_us,
  input  rsc_pkg::cfg_t                   cfg,
  output rsc_pkg::meta_t                  meta,
  output logic [rsc_pkg::ANGLE_BITS-1:0]  elev,
  output logic [rsc_pkg::ANGLE_BITS-1:0]  azim
);
  import rsc_pkg::*;

  localparam logic [SWEEP_PW-1:0] SWEEP_HALF = SWEEP_PW'(1) << 15;

  meta_t                 s1_meta_r, s2_meta_r, s3_meta_r;
  meta_t                 s1_meta_nxt;
  logic [ANGLE_BITS-1:0] s1_elev_r, s2_elev_r, s3_elev_r;
  logic [ANGLE_BITS-1:0] s1_elev_nxt;
  logic [SWEEP_PW-1:0]   s1_sprod_r, s1_sprod_nxt;
  logic [ELEV_PW-1:0]    elev_prod;
  logic [SWEEP_PW-1:0]   sweep_sum;
  logic [ANGLE_BITS-1:0] s2_sweep_r, s2_sweep_nxt;
  logic [ANGLE_BITS-1:0] s3_azim_r, s3_azim_nxt;
  logic [ANGLE_BITS-1:0] start_ang;

  // stage 1: products
  always_comb begin
    s1_meta_nxt.vld      = req_vld;
    s1_meta_nxt.bad      = {1'b0, beam_index} >= BEAM_LIMIT;
    s1_meta_nxt.range_mm = range_mm;
    elev_prod            = ELEV_PW'(beam_index) * ELEV_PW'(cfg.beam_step);
    s1_elev_nxt          = elev_prod[ANGLE_BITS-1:0];
    // only the low bits of the sweep product survive the wrap
    s1_sprod_nxt         = SWEEP_PW'(elapsed_us) * SWEEP_PW'(cfg.rotation_rate);
  end

  // stage 2: round the sweep angle, half up
  always_comb begin
    sweep_sum    = s1_sprod_r + SWEEP_HALF;
    s2_sweep_nxt = sweep_sum[SWEEP_PW-1:16];
  end

  // stage 3: azimuth
  always_comb begin
    start_ang = ANGLE_BITS'(cfg.start_azimuth);
    if (cfg.sweep_reverse) begin
      s3_azim_nxt = start_ang + s2_sweep_r;
    end else begin
      s3_azim_nxt = start_ang - s2_sweep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_meta_r <= '0;
      s2_meta_r <= '0;
      s3_meta_r <= '0;
    end else begin
      s1_meta_r <= s1_meta_nxt;
      s2_meta_r <= s1_meta_r;
      s3_meta_r <= s2_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_elev_r  <= s1_elev_nxt;
    s1_sprod_r <= s1_sprod_nxt;
    s2_elev_r  <= s1_elev_r;
    s2_sweep_r <= s2_sweep_nxt;
    s3_elev_r  <= s2_elev_r;
    s3_azim_r  <= s3_azim_nxt;
  end

  assign meta = s3_meta_r;
  assign elev = s3_elev_r;
  assign azim = s3_azim_r;

endmodule

[rtl/core/rsc_sincos.sv]
// ----------------------------------------------------------------------------
// rsc_sincos
// Sine and cosine of a binary angle in Q1.15, quarter-wave odd polynomial
// evaluated by Horner steps, at most one multiply per register stage.
// ----------------------------------------------------------------------------
module rsc_sincos (
  input  logic                           clk,
  input  logic [rsc_pkg::ANGLE_BITS-1:0] ang,
  output rsc_pkg::trig_t                 sin_val,
  output rsc_pkg::trig_t                 cos_val
);
  import rsc_pkg::*;

  localparam int          LANES   = 2;
  localparam int          NEG_LEN = SC_LAT - 1;
  localparam int          U_W     = 31;
  localparam logic [16:0] ONE_Q15 = 17'd32768;

  // lane 0 is sine, lane 1 cosine
  logic [1:0]         quad;
  logic [QTR_W-1:0]   frac;
  logic [QTR_W-1:0]   arg_nxt [LANES];
  logic               neg_nxt [LANES];

  logic [QTR_W-1:0]   s0_arg_r [LANES];
  logic [NEG_LEN-1:0] neg_r    [LANES];

  logic [U_W-1:0]     u_nxt    [LANES];
  logic [61:0]        m1       [LANES];
  logic [48:0]        m2       [LANES];
  logic [53:0]        m3       [LANES];
  logic [57:0]        m4       [LANES];
  logic [60:0]        m5       [LANES];
  logic [61:0]        m6       [LANES];
  logic [31:0]        rnd      [LANES];
  logic [16:0]        mag      [LANES];
  trig_t              res_nxt  [LANES];

  logic [U_W-1:0]     s1_u_r  [LANES], s2_u_r [LANES], s3_u_r [LANES];
  logic [U_W-1:0]     s4_u_r  [LANES], s5_u_r [LANES];
  logic [U_W-1:0]     s1_u2_r [LANES], s2_u2_r [LANES], s3_u2_r [LANES];
  logic [U_W-1:0]     s4_u2_r [LANES];
  logic [22:0]        s2_p_r  [LANES], s2_p_nxt [LANES];
  logic [26:0]        s3_p_r  [LANES], s3_p_nxt [LANES];
  logic [29:0]        s4_p_r  [LANES], s4_p_nxt [LANES];
  logic [30:0]        s5_p_r  [LANES], s5_p_nxt [LANES];
  logic [30:0]        s6_p_r  [LANES], s6_p_nxt [LANES];
  trig_t              s7_res_r [LANES];

  // quadrant folding, cos(a) is sin(a + quarter)
  always_comb begin
    quad       = ang[ANGLE_BITS-1 -: 2];
    frac       = QTR_W'(ang[ANGLE_BITS-3:0]);
    arg_nxt[0] = quad[0] ? (QUARTER - frac) : frac;
    arg_nxt[1] = quad[0] ? frac : (QUARTER - frac);
    neg_nxt[0] = quad[1];
    neg_nxt[1] = quad[1] ^ quad[0];
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      u_nxt[l]    = U_W'(s0_arg_r[l]) << TO_Q30;
      m1[l]       = 62'(u_nxt[l]) * 62'(u_nxt[l]);
      m2[l]       = 49'(K9) * 49'(s1_u2_r[l]);
      s2_p_nxt[l] = K7 - 23'(m2[l][48:30]);
      m3[l]       = 54'(s2_p_r[l]) * 54'(s2_u2_r[l]);
      s3_p_nxt[l] = K5 - 27'(m3[l][53:30]);
      m4[l]       = 58'(s3_p_r[l]) * 58'(s3_u2_r[l]);
      s4_p_nxt[l] = K3 - 30'(m4[l][57:30]);
      m5[l]       = 61'(s4_p_r[l]) * 61'(s4_u2_r[l]);
      s5_p_nxt[l] = K1 - m5[l][60:30];
      m6[l]       = 62'(s5_p_r[l]) * 62'(s5_u_r[l]);
      s6_p_nxt[l] = 31'(m6[l][61:30]);
      // round to Q15 and clamp at one
      rnd[l]      = 32'(s6_p_r[l]) + 32'd16384;
      mag[l]      = (rnd[l][31:15] > ONE_Q15) ? ONE_Q15 : rnd[l][31:15];
      res_nxt[l]  = neg_r[l][NEG_LEN-1] ? trig_t'(-mag[l]) : trig_t'(mag[l]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      s0_arg_r[l] <= arg_nxt[l];
      neg_r[l]    <= {neg_r[l][NEG_LEN-2:0], neg_nxt[l]};
      s1_u_r[l]   <= u_nxt[l];
      s1_u2_r[l]  <= m1[l][60:30];
      s2_u_r[l]   <= s1_u_r[l];
      s2_u2_r[l]  <= s1_u2_r[l];
      s2_p_r[l]   <= s2_p_nxt[l];
      s3_u_r[l]   <= s2_u_r[l];
      s3_u2_r[l]  <= s2_u2_r[l];
      s3_p_r[l]   <= s3_p_nxt[l];
      s4_u_r[l]   <= s3_u_r[l];
      s4_u2_r[l]  <= s3_u2_r[l];
      s4_p_r[l]   <= s4_p_nxt[l];
      s5_u_r[l]   <= s4_u_r[l];
      s5_p_r[l]   <= s5_p_nxt[l];
      s6_p_r[l]   <= s6_p_nxt[l];
      s7_res_r[l] <= res_nxt[l];
    end
  end

  assign sin_val = s7_res_r[0];
  assign cos_val = s7_res_r[1];

endmodule

[rtl/core/rsc_project.sv]
// ----------------------------------------------------------------------------
// rsc_project
// Scales the range by the trig terms and rounds to millimetres, halves away
// from zero, three register stages.
// ----------------------------------------------------------------------------
module rsc_project (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rsc_pkg::meta_t               meta,
  input  rsc_pkg::trig_t               sin_elev,
  input  rsc_pkg::trig_t               cos_elev,
  input  rsc_pkg::trig_t               sin_azim,
  input  rsc_pkg::trig_t               cos_azim,
  output logic                         pt_vld,
  output logic [rsc_pkg::COORD_W-1:0]  pt_x,
  output logic [rsc_pkg::COORD_W-1:0]  pt_y,
  output logic [rsc_pkg::COORD_W-1:0]  pt_z
);
  import rsc_pkg::*;

  localparam int PW1 = 34;
  localparam int PW2 = 48;
  localparam logic [PW2-1:0] HALF_XY = PW2'(1) << 29;
  localparam logic [PW1-1:0] HALF_Z  = PW1'(1) << 14;

  logic signed [RANGE_W:0] range_s;
  logic signed [PW1-1:0]  s1_rs_nxt, s1_rc_nxt;
  logic signed [PW1-1:0]  s1_rs_r, s1_rc_r, s2_rc_r;
  trig_t                  s1_sa_r, s1_ca_r;
  logic signed [PW2-1:0]  s2_vx_nxt, s2_vy_nxt;
  logic signed [PW2-1:0]  s2_vx_r, s2_vy_r;
  meta_t                  s1_meta_r, s2_meta_r;
  logic [PW2-1:0]         sum_x, sum_y;
  logic [PW1-1:0]         sum_z;
  logic [COORD_W-1:0]     x_nxt, y_nxt, z_nxt;
  logic                   vld_r;
  logic [COORD_W-1:0]     x_r, y_r, z_r;

  always_comb begin
    range_s   = $signed({1'b0, meta.range_mm});
    s1_rs_nxt = PW1'(range_s) * PW1'(sin_elev);
    s1_rc_nxt = PW1'(range_s) * PW1'(cos_elev);
    s2_vx_nxt = PW2'(s1_rs_r) * PW2'(s1_ca_r);
    s2_vy_nxt = PW2'(s1_rs_r) * PW2'(s1_sa_r);
  end

  // adding half minus one for negatives then flooring rounds halves outward
  always_comb begin
    sum_x = s2_vx_r + HALF_XY - PW2'(s2_vx_r[PW2-1]);
    sum_y = s2_vy_r + HALF_XY - PW2'(s2_vy_r[PW2-1]);
    sum_z = s2_rc_r + HALF_Z - PW1'(s2_rc_r[PW1-1]);
    if (s2_meta_r.bad) begin
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
    end else begin
      x_nxt = sum_x[30 +: COORD_W];
      y_nxt = sum_y[30 +: COORD_W];
      z_nxt = sum_z[15 +: COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_meta_r <= '0;
      s2_meta_r <= '0;
      vld_r     <= 1'b0;
    end else begin
      s1_meta_r <= meta;
      s2_meta_r <= s1_meta_r;
      vld_r     <= s2_meta_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_rs_r <= s1_rs_nxt;
    s1_rc_r <= s1_rc_nxt;
    s1_sa_r <= sin_azim;
    s1_ca_r <= cos_azim;
    s2_vx_r <= s2_vx_nxt;
    s2_vy_r <= s2_vy_nxt;
    s2_rc_r <= s1_rc_r;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
  end

  assign pt_vld = vld_r;
  assign pt_x   = x_r;
  assign pt_y   = y_r;
  assign pt_z   = z_r;

endmodule

[rtl/core/rotating_scan_to_cartesian_core.sv]
// ----------------------------------------------------------------------------
// rotating_scan_to_cartesian_core
// Turns one range sample of a motor-swept 2D scanner into a 3D point in mm.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-----------------------
//   request  | in_range_mm, in_beam_index, in_elapsed_us | start & !busy
//   result   | out_point_x, out_point_y, out_point_z   | out_valid, one cycle
//   config   | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
// One request per clock; busy stays low and cfg_ready stays high.
// A request passes the angle stages, the sine/cosine polynomial
// chain (one multiply per stage), then the scaling and rounding stages.
// rst_n clears the registers to their defaults and the pipeline valid bits.
// The receiver cannot stall, so results leave on a fixed schedule.
// ----------------------------------------------------------------------------
module rotating_scan_to_cartesian_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rsc_pkg::RANGE_W-1:0]     in_range_mm,
  input  logic [rsc_pkg::BEAM_W-1:0]      in_beam_index,
  input  logic [rsc_pkg::TIME_W-1:0]      in_elapsed_us,
  output logic                            out_valid,
  output logic [rsc_pkg::COORD_W-1:0]     out_point_x,
  output logic [rsc_pkg::COORD_W-1:0]     out_point_y,
  output logic [rsc_pkg::COORD_W-1:0]     out_point_z,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rsc_pkg::*;

  cfg_t                  cfg_r, cfg_nxt;
  logic                  req_vld;
  meta_t                 ang_meta;
  logic [ANGLE_BITS-1:0] ang_elev, ang_azim;
  meta_t                 dly_r [SC_LAT];
  trig_t                 sin_elev, cos_elev, sin_azim, cos_azim;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign req_vld   = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    unique case (cfg_index)
      REG_BEAM_STEP:     cfg_nxt.beam_step     = cfg_data[STEP_W-1:0];
      REG_START_AZIMUTH: cfg_nxt.start_azimuth = cfg_data[STEP_W-1:0];
      REG_ROTATION_RATE: cfg_nxt.rotation_rate = cfg_data[RATE_W-1:0];
      REG_SWEEP_REVERSE: cfg_nxt.sweep_reverse = cfg_data[0];
      default:           cfg_nxt = cfg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_nxt;
    end
  end

  rsc_angle u_angle (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_vld    (req_vld),
    .range_mm   (in_range_mm),
    .beam_index (in_beam_index),
    .elapsed_us (in_elapsed_us),
    .cfg        (cfg_r),
    .meta       (ang_meta),
    .elev       (ang_elev),
    .azim       (ang_azim)
  );

  rsc_sincos u_sc_elev (
    .clk     (clk),
    .ang     (ang_elev),
    .sin_val (sin_elev),
    .cos_val (cos_elev)
  );

  rsc_sincos u_sc_azim (
    .clk     (clk),
    .ang     (ang_azim),
    .sin_val (sin_azim),
    .cos_val (cos_azim)
  );

  // request control follows the trig pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SC_LAT; i++) begin
        dly_r[i] <= '0;
      end
    end else begin
      dly_r[0] <= ang_meta;
      for (int i = 1; i < SC_LAT; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  rsc_project u_project (
    .clk      (clk),
    .rst_n    (rst_n),
    .meta     (dly_r[SC_LAT-1]),
    .sin_elev (sin_elev),
    .cos_elev (cos_elev),
    .sin_azim (sin_azim),
    .cos_azim (cos_azim),
    .pt_vld   (out_valid),
    .pt_x     (out_point_x),
    .pt_y     (out_point_y),
    .pt_z     (out_point_z)
  );

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching request");

  a_bad_beam_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past({1'b0, in_beam_index} >= BEAM_LIMIT, PIPE_LAT) |->
      out_point_x == '0 && out_point_y == '0 && out_point_z == '0)
    else $error("beam outside the line gave a nonzero point");

  a_zero_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_range_mm == '0, PIPE_LAT) |->
      out_point_x == '0 && out_point_y == '0 && out_point_z == '0)
    else $error("zero range gave a nonzero point");

endmodule
